### design/brpa_pkg.sv
// Shared types and constants of the byte-range patch applier.
`timescale 1ns / 1ps

package brpa_pkg;

   // header, data and error phases of one patch job
   typedef enum logic [2:0] {
      PH_SIG0      = 3'd0,
      PH_SIG1      = 3'd1,
      PH_COUNT     = 3'd2,
      PH_LIST      = 3'd3,
      PH_DATA      = 3'd4,
      PH_ERR_SIG   = 3'd5,
      PH_ERR_COUNT = 3'd6
   } phase_type;

   // item kinds on the request side
   typedef enum logic [1:0] {
      CMD_PATCH    = 2'd0,
      CMD_ORIGINAL = 2'd1,
      CMD_RESTART  = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SIG   = 2'd1,
      ST_TOO_MANY  = 2'd2,
      ST_WRONG_CMD = 2'd3
   } status_type;

   localparam int VALUE_WIDTH = 32;

   localparam logic [7:0] SIG_BYTE0 = 8'hFF;
   localparam logic [7:0] SIG_BYTE1 = 8'h98;
   localparam logic [7:0] CHAR_NL   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

endpackage

### design/brpa_ram.sv
// Generic RAM, one write port and two registered read ports, write-first.
`timescale 1ns / 1ps

module brpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, a word written this cycle is forwarded
   always_ff @(posedge clock) begin
      if (wr_en && wr_addr == rd_addr_a) begin
         rd_a_ff <= wr_data;
      end else begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (wr_en && wr_addr == rd_addr_b) begin
         rd_b_ff <= wr_data;
      end else begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### design/byte_range_patch_apply.sv
// Top level of the byte-range patch applier.
//
// Usage: words arrive on the req_ stream; req_tuser carries the kind (patch
// byte, original byte, restart) and req_tdata the byte. First the patch
// header is sent as patch words: signature 0xFF 0x98, a decimal count line
// and that many decimal boundary lines. Header words give no result unless
// they fail. Afterwards original words are sent for positions outside every
// range and patch words for positions inside one; each gives one merged word
// on the rsp_ stream, with its origin and status in rsp_tuser.
// rsp_tvalid rises in the cycle after accept; one word is taken every cycle
// while the receiver keeps up, the boundary table read ahead on two registered
// ports so the next start and end boundaries are ready for the following word.
// A word is accepted while the result register is empty or being emptied,
// so a stalled receiver holds back the request side after one word.
// Reset (synchronous) and the restart kind both return to the signature
// phase; the boundary table needs no clearing since only entries loaded
// since then are ever compared.
`timescale 1ns / 1ps

module byte_range_patch_apply
   import brpa_pkg::*;
#(
   parameter int MAX_BOUNDARIES = 64,
   parameter int POSITION_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // byte_in [7:0]
   input  logic [1:0] req_tuser,   // cmd [1:0]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte [7:0]
   output logic [2:0] rsp_tuser    // from_patch [0], status [2:1]
);

   localparam int AW = $clog2(MAX_BOUNDARIES);
   localparam int NW = $clog2(MAX_BOUNDARIES + 1);
   localparam int SW = $clog2(MAX_BOUNDARIES + 2);
   localparam int VW = VALUE_WIDTH;
   localparam int CW = (POSITION_WIDTH > VW) ? POSITION_WIDTH : VW;

   phase_type               phase_ff, phase_in;
   logic [VW-1:0]           acc_ff, acc_in;
   logic [NW-1:0]           count_ff, count_in;
   logic [NW-1:0]           loaded_ff, loaded_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [SW-1:0]           start_slot_ff, start_slot_in;
   logic [SW-1:0]           end_slot_ff, end_slot_in;
   logic                    replacing_ff, replacing_in;

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_patch_ff, rsp_patch_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    emit;

   logic                    accept;
   cmd_type                 cmd;
   logic [VW-1:0]           start_val;
   logic [VW-1:0]           end_val;
   logic                    tbl_we;
   logic [VW+3:0]           acc_sum;
   logic                    is_digit;
   logic                    start_hit;
   logic                    end_hit;
   logic                    rep;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);

   // boundary table, read ahead at the next start and end slots
   brpa_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_BOUNDARIES)
   ) u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   (loaded_ff[AW-1:0]),
      .wr_data   (acc_ff),
      .rd_addr_a (start_slot_in[AW-1:0]),
      .rd_data_a (start_val),
      .rd_addr_b (end_slot_in[AW-1:0]),
      .rd_data_b (end_val)
   );

   // decimal accumulate with saturation
   always_comb begin
      acc_sum  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
               + (VW + 4)'(req_tdata[3:0] - CHAR_ZERO[3:0]);
      is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
   end

   // boundary matches at the current position
   always_comb begin
      start_hit = (start_slot_ff < SW'(loaded_ff))
               && (CW'(start_val) == CW'(pos_ff));
      end_hit   = (end_slot_ff < SW'(loaded_ff))
               && (CW'(end_val) == CW'(pos_ff));
      rep = replacing_ff;
      if (start_hit) begin
         rep = 1'b1;
      end
      if (end_hit) begin
         rep = 1'b0;
      end
   end

   // next state and result
   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      loaded_in     = loaded_ff;
      pos_in        = pos_ff;
      start_slot_in = start_slot_ff;
      end_slot_in   = end_slot_ff;
      replacing_in  = replacing_ff;
      tbl_we        = 1'b0;
      emit          = 1'b0;
      rsp_byte_in   = 8'd0;
      rsp_patch_in  = 1'b0;
      rsp_status_in = ST_OK;

      if (accept) begin
         if (cmd == CMD_RESTART) begin
            phase_in      = PH_SIG0;
            acc_in        = '0;
            count_in      = '0;
            loaded_in     = '0;
            pos_in        = '0;
            start_slot_in = '0;
            end_slot_in   = SW'(1);
            replacing_in  = 1'b0;
         end else if (cmd != CMD_UNUSED) begin
            unique case (phase_ff)
               PH_ERR_SIG: begin
                  emit          = 1'b1;
                  rsp_status_in = ST_BAD_SIG;
               end
               PH_ERR_COUNT: begin
                  emit          = 1'b1;
                  rsp_status_in = ST_TOO_MANY;
               end
               PH_DATA: begin
                  if ((rep && cmd != CMD_PATCH) || (!rep && cmd != CMD_ORIGINAL)) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_WRONG_CMD;
                  end else begin
                     if (start_hit) begin
                        start_slot_in = start_slot_ff + SW'(2);
                     end
                     if (end_hit) begin
                        end_slot_in = end_slot_ff + SW'(2);
                     end
                     replacing_in = rep;
                     pos_in       = pos_ff + POSITION_WIDTH'(1);
                     emit         = 1'b1;
                     rsp_byte_in  = req_tdata;
                     rsp_patch_in = rep;
                  end
               end
               PH_SIG0, PH_SIG1, PH_COUNT, PH_LIST: begin
                  if (cmd != CMD_PATCH) begin
                     emit          = 1'b1;
                     rsp_status_in = ST_WRONG_CMD;
                  end else if (phase_ff == PH_SIG0) begin
                     if (req_tdata != SIG_BYTE0) begin
                        phase_in      = PH_ERR_SIG;
                        emit          = 1'b1;
                        rsp_status_in = ST_BAD_SIG;
                     end else begin
                        phase_in = PH_SIG1;
                     end
                  end else if (phase_ff == PH_SIG1) begin
                     if (req_tdata != SIG_BYTE1) begin
                        phase_in      = PH_ERR_SIG;
                        emit          = 1'b1;
                        rsp_status_in = ST_BAD_SIG;
                     end else begin
                        phase_in = PH_COUNT;
                        acc_in   = '0;
                     end
                  end else if (is_digit) begin
                     if (acc_sum[VW+3:VW] != 4'd0) begin
                        acc_in = '1;
                     end else begin
                        acc_in = acc_sum[VW-1:0];
                     end
                  end else if (req_tdata == CHAR_NL) begin
                     if (phase_ff == PH_COUNT) begin
                        if (acc_ff > VW'(MAX_BOUNDARIES)) begin
                           phase_in      = PH_ERR_COUNT;
                           emit          = 1'b1;
                           rsp_status_in = ST_TOO_MANY;
                        end else begin
                           count_in  = acc_ff[NW-1:0];
                           loaded_in = '0;
                           acc_in    = '0;
                           phase_in  = (acc_ff == '0) ? PH_DATA : PH_LIST;
                        end
                     end else begin
                        // boundary line ends: store it
                        tbl_we    = 1'b1;
                        loaded_in = loaded_ff + NW'(1);
                        acc_in    = '0;
                        if (loaded_ff + NW'(1) >= count_ff) begin
                           phase_in = PH_DATA;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIG0;
         acc_ff        <= '0;
         count_ff      <= '0;
         loaded_ff     <= '0;
         pos_ff        <= '0;
         start_slot_ff <= '0;
         end_slot_ff   <= SW'(1);
         replacing_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         acc_ff        <= acc_in;
         count_ff      <= count_in;
         loaded_ff     <= loaded_in;
         pos_ff        <= pos_in;
         start_slot_ff <= start_slot_in;
         end_slot_ff   <= end_slot_in;
         replacing_ff  <= replacing_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_patch_ff  <= rsp_patch_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_patch_ff};

endmodule
